// File: sv/skdm_pkg.sv
package skdm_pkg;

   localparam int INDEX_BITS_DEF = 32;
   localparam int VALUE_BITS_DEF = 32;
   localparam int COUNT_BITS     = 32;
   localparam int POLICY_BITS    = 3;

   localparam logic [POLICY_BITS-1:0] POLICY_SUM  = 3'd0;
   localparam logic [POLICY_BITS-1:0] POLICY_AVG  = 3'd1;
   localparam logic [POLICY_BITS-1:0] POLICY_MAX  = 3'd2;
   localparam logic [POLICY_BITS-1:0] POLICY_MIN  = 3'd3;
   localparam logic [POLICY_BITS-1:0] POLICY_LAST = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic merge;
      logic div_start;
      logic avg_write;
      logic load_new;
      logic emit;
      logic emit_final;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic match;
      logic pend_valid;
      logic policy_avg;
      logic end_flag;
      logic out_free;
      logic div_done;
   } status_type;

endpackage

// File: sv/skdm_ifs.sv
interface skdm_req_if #(
   parameter int INDEX_BITS = skdm_pkg::INDEX_BITS_DEF,
   parameter int VALUE_BITS = skdm_pkg::VALUE_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic [INDEX_BITS-1:0]        row_index;
   logic [INDEX_BITS-1:0]        col_index;
   logic signed [VALUE_BITS-1:0] entry_value;
   logic                         stream_end;

   modport source (output valid, row_index, col_index, entry_value, stream_end, input ready);
   modport sink (input valid, row_index, col_index, entry_value, stream_end, output ready);
endinterface

interface skdm_rsp_if #(
   parameter int INDEX_BITS = skdm_pkg::INDEX_BITS_DEF,
   parameter int VALUE_BITS = skdm_pkg::VALUE_BITS_DEF
);
   logic                              valid;
   logic                              ready;
   logic [INDEX_BITS-1:0]             out_row;
   logic [INDEX_BITS-1:0]             out_col;
   logic signed [VALUE_BITS-1:0]      out_value;
   logic [skdm_pkg::COUNT_BITS-1:0]   merged_count;
   logic                              final_result;

   modport source (output valid, out_row, out_col, out_value, merged_count, final_result,
                   input ready);
   modport sink (input valid, out_row, out_col, out_value, merged_count, final_result,
                 output ready);
endinterface

interface skdm_csr_if;
   logic                               valid;
   logic                               ready;
   logic [skdm_pkg::POLICY_BITS-1:0]   merge_policy;

   modport source (output valid, merge_policy, input ready);
   modport sink (input valid, merge_policy, output ready);
endinterface

// File: sv/skdm_div.sv
module skdm_div #(
   parameter int VALUE_BITS = skdm_pkg::VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [VALUE_BITS-1:0]           dividend,
   input  logic [skdm_pkg::COUNT_BITS-1:0] divisor,
   output logic                            done,
   output logic [VALUE_BITS-1:0]           quotient
);
   localparam int CB    = skdm_pkg::COUNT_BITS;
   localparam int CNT_W = $clog2(VALUE_BITS + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CB-1:0]    rem_ff, rem_in;
   logic [CB-1:0]    dvs_ff, dvs_in;
   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [CB:0]      rem_sh;
   logic [CB:0]      rem_sub;

   assign rem_sh  = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(VALUE_BITS);
         rem_in  = '0;
         dvs_in  = divisor;
         quot_in = dividend;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in  = rem_sub[CB-1:0];
            quot_in = {quot_ff[VALUE_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[CB-1:0];
            quot_in = {quot_ff[VALUE_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: sv/skdm_datapath.sv
module skdm_datapath #(
   parameter int INDEX_BITS = skdm_pkg::INDEX_BITS_DEF,
   parameter int VALUE_BITS = skdm_pkg::VALUE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  skdm_pkg::cmd_type                cmd,
   output skdm_pkg::status_type             status,
   input  logic [INDEX_BITS-1:0]            req_row_index,
   input  logic [INDEX_BITS-1:0]            req_col_index,
   input  logic signed [VALUE_BITS-1:0]     req_entry_value,
   input  logic                             req_stream_end,
   input  logic                             csr_valid,
   input  logic [skdm_pkg::POLICY_BITS-1:0] csr_merge_policy,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [INDEX_BITS-1:0]            rsp_out_row,
   output logic [INDEX_BITS-1:0]            rsp_out_col,
   output logic signed [VALUE_BITS-1:0]     rsp_out_value,
   output logic [skdm_pkg::COUNT_BITS-1:0]  rsp_merged_count,
   output logic                             rsp_final_result
);
   localparam int CB = skdm_pkg::COUNT_BITS;
   localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   logic [skdm_pkg::POLICY_BITS-1:0] policy_ff;

   logic [INDEX_BITS-1:0]        in_row_ff, in_col_ff;
   logic signed [VALUE_BITS-1:0] in_val_ff;
   logic                         in_end_ff;

   logic                         pend_valid_ff;
   logic [INDEX_BITS-1:0]        pend_row_ff, pend_col_ff;
   logic signed [VALUE_BITS-1:0] pend_val_ff, pend_val_in;
   logic [CB-1:0]                pend_count_ff, count_inc;

   logic                         out_valid_ff;
   logic [INDEX_BITS-1:0]        out_row_ff, out_col_ff;
   logic signed [VALUE_BITS-1:0] out_val_ff;
   logic [CB-1:0]                out_count_ff;
   logic                         out_final_ff;

   logic signed [VALUE_BITS:0]   sum_ext, diff_ext;
   logic signed [VALUE_BITS-1:0] sum_sat, avg_val;
   logic                         up_dir;
   logic [VALUE_BITS-1:0]        mag;
   logic                         div_done;
   logic [VALUE_BITS-1:0]        quot;

   assign sum_ext = {pend_val_ff[VALUE_BITS-1], pend_val_ff}
                  + {in_val_ff[VALUE_BITS-1], in_val_ff};
   always_comb begin
      if (sum_ext[VALUE_BITS] != sum_ext[VALUE_BITS-1]) begin
         sum_sat = sum_ext[VALUE_BITS] ? VAL_MIN : VAL_MAX;
      end else begin
         sum_sat = sum_ext[VALUE_BITS-1:0];
      end
   end

   assign up_dir   = (in_val_ff >= pend_val_ff);
   assign diff_ext = up_dir
      ? ({in_val_ff[VALUE_BITS-1], in_val_ff} - {pend_val_ff[VALUE_BITS-1], pend_val_ff})
      : ({pend_val_ff[VALUE_BITS-1], pend_val_ff} - {in_val_ff[VALUE_BITS-1], in_val_ff});
   assign mag      = diff_ext[VALUE_BITS-1:0];
   assign avg_val  = up_dir ? (pend_val_ff + quot) : (pend_val_ff - quot);

   assign count_inc = (pend_count_ff == {CB{1'b1}}) ? pend_count_ff : pend_count_ff + CB'(1);

   always_comb begin
      case (policy_ff)
         skdm_pkg::POLICY_SUM:  pend_val_in = sum_sat;
         skdm_pkg::POLICY_MAX:  pend_val_in = (in_val_ff > pend_val_ff) ? in_val_ff : pend_val_ff;
         skdm_pkg::POLICY_MIN:  pend_val_in = (in_val_ff < pend_val_ff) ? in_val_ff : pend_val_ff;
         skdm_pkg::POLICY_LAST: pend_val_in = in_val_ff;
         default:               pend_val_in = pend_val_ff;
      endcase
   end

   skdm_div #(
      .VALUE_BITS(VALUE_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(mag),
      .divisor (pend_count_ff),
      .done    (div_done),
      .quotient(quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= skdm_pkg::POLICY_SUM;
      end else if (csr_valid) begin
         policy_ff <= csr_merge_policy;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_row_ff <= req_row_index;
         in_col_ff <= req_col_index;
         in_val_ff <= req_entry_value;
         in_end_ff <= req_stream_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_count_ff <= '0;
      end else if (cmd.clear) begin
         pend_valid_ff <= 1'b0;
         pend_count_ff <= '0;
      end else if (cmd.load_new) begin
         pend_valid_ff <= 1'b1;
         pend_count_ff <= CB'(1);
      end else if (cmd.merge) begin
         pend_count_ff <= count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_new) begin
         pend_row_ff <= in_row_ff;
         pend_col_ff <= in_col_ff;
         pend_val_ff <= in_val_ff;
      end else if (cmd.merge) begin
         pend_val_ff <= pend_val_in;
      end else if (cmd.avg_write) begin
         pend_val_ff <= avg_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         out_row_ff   <= pend_row_ff;
         out_col_ff   <= pend_col_ff;
         out_val_ff   <= pend_val_ff;
         out_count_ff <= pend_count_ff;
         out_final_ff <= cmd.emit_final;
      end
   end

   assign status.match      = pend_valid_ff && (in_row_ff == pend_row_ff)
                              && (in_col_ff == pend_col_ff);
   assign status.pend_valid = pend_valid_ff;
   assign status.policy_avg = (policy_ff == skdm_pkg::POLICY_AVG);
   assign status.end_flag   = in_end_ff;
   assign status.out_free   = !out_valid_ff || rsp_ready;
   assign status.div_done   = div_done;

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_row      = out_row_ff;
   assign rsp_out_col      = out_col_ff;
   assign rsp_out_value    = out_val_ff;
   assign rsp_merged_count = out_count_ff;
   assign rsp_final_result = out_final_ff;

`ifndef SYNTHESIS
   // A pending entry always carries at least one merged word.
   assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (pend_count_ff != '0))
      else $error("pending entry with zero count");

   // Only a held entry may be emitted, and never over an untaken result.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (pend_valid_ff && (!out_valid_ff || rsp_ready)))
      else $error("emit without pending entry or free output");

   // A merge never lowers the count.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.merge && !cmd.clear && !cmd.load_new) |=> (pend_count_ff >= $past(pend_count_ff)))
      else $error("merge count decreased");

   // The average quotient never exceeds the difference it came from.
   assert property (@(posedge clock) disable iff (reset)
      cmd.avg_write |-> (quot <= mag))
      else $error("average quotient out of range");
`endif

endmodule

// File: sv/skdm_ctrl.sv
module skdm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  skdm_pkg::status_type status,
   output skdm_pkg::cmd_type    cmd
);
   skdm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skdm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         skdm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = skdm_pkg::ST_EVAL;
            end
         end
         skdm_pkg::ST_EVAL: begin
            if (status.match) begin
               cmd.merge = 1'b1;
               state_in  = status.policy_avg ? skdm_pkg::ST_DIV_START : skdm_pkg::ST_FINISH;
            end else if (status.pend_valid) begin
               state_in = skdm_pkg::ST_FLUSH;
            end else begin
               cmd.load_new = 1'b1;
               state_in     = skdm_pkg::ST_FINISH;
            end
         end
         skdm_pkg::ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = skdm_pkg::ST_DIV_WAIT;
         end
         skdm_pkg::ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.avg_write = 1'b1;
               state_in      = skdm_pkg::ST_FINISH;
            end
         end
         skdm_pkg::ST_FLUSH: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.load_new = 1'b1;
               state_in     = skdm_pkg::ST_FINISH;
            end
         end
         skdm_pkg::ST_FINISH: begin
            if (!status.end_flag) begin
               state_in = skdm_pkg::ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_final = 1'b1;
               cmd.clear      = 1'b1;
               state_in       = skdm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skdm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: sv/sorted_key_duplicate_merge_top.sv
// Channel   Role    Word
// req_chan  sink    row_index, col_index, entry_value, stream_end
// rsp_chan  source  out_row, out_col, out_value, merged_count, final_result
// csr_chan  sink    merge_policy
//
// A word that merges or starts a new entry passes the idle, eval and finish states; a word
// that flushes one also passes flush. An average merge waits on the radix-2 divider.
// The merged word sits in one output register; a stalled output holds the block only
// when a further word has to be emitted. Reset is synchronous and clears the policy to sum.
module sorted_key_duplicate_merge_top #(
   parameter int INDEX_BITS = skdm_pkg::INDEX_BITS_DEF,
   parameter int VALUE_BITS = skdm_pkg::VALUE_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   skdm_req_if.sink  req_chan,
   skdm_rsp_if.source rsp_chan,
   skdm_csr_if.sink  csr_chan
);
   skdm_pkg::cmd_type    cmd;
   skdm_pkg::status_type status;
   logic                 req_ready;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   skdm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   skdm_datapath #(
      .INDEX_BITS(INDEX_BITS),
      .VALUE_BITS(VALUE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_row_index   (req_chan.row_index),
      .req_col_index   (req_chan.col_index),
      .req_entry_value (req_chan.entry_value),
      .req_stream_end  (req_chan.stream_end),
      .csr_valid       (csr_chan.valid),
      .csr_merge_policy(csr_chan.merge_policy),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_out_row     (rsp_chan.out_row),
      .rsp_out_col     (rsp_chan.out_col),
      .rsp_out_value   (rsp_chan.out_value),
      .rsp_merged_count(rsp_chan.merged_count),
      .rsp_final_result(rsp_chan.final_result)
   );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int IW            = skdm_pkg::INDEX_BITS_DEF;
   localparam int VW            = skdm_pkg::VALUE_BITS_DEF;
   localparam int PW            = skdm_pkg::POLICY_BITS;
   localparam int CW            = skdm_pkg::COUNT_BITS;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = VW + 24;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ENTRIES = 67;

   localparam logic [PW-1:0]        POLICY_UNDEFINED = 3'd7;
   localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

   typedef struct {
      logic [IW-1:0]         row;
      logic [IW-1:0]         col;
      logic signed [VW-1:0]  value;
      logic [CW-1:0]         count;
      logic                  fin;
   } merged_entry_type;

   class merge_scoreboard_type;
      logic [PW-1:0]          policy;
      bit                     held;
      logic [IW-1:0]          held_row;
      logic [IW-1:0]          held_col;
      logic signed [VW-1:0]   held_value;
      logic [CW-1:0]          held_count;
      merged_entry_type       awaited[$];
      int                     faults;

      function new();
         policy = skdm_pkg::POLICY_SUM;
         faults = 0;
         clear_held();
      endfunction

      function void clear_held();
         held = 1'b0;
         held_row = '0;
         held_col = '0;
         held_value = '0;
         held_count = '0;
      endfunction

      function void set_policy(logic [PW-1:0] p);
         policy = p;
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction

      function void flush_held(logic fin);
         merged_entry_type e;
         e.row = held_row;
         e.col = held_col;
         e.value = held_value;
         e.count = held_count;
         e.fin = fin;
         awaited.push_back(e);
      endfunction

      // The count already includes the new entry when the average is taken.
      function logic signed [VW-1:0] fold(logic signed [VW-1:0] nv);
         longint a;
         longint b;
         longint n;
         longint r;
         a = held_value;
         b = nv;
         n = held_count;
         r = a;
         case (policy)
            skdm_pkg::POLICY_SUM: begin
               r = a + b;
               if (r > longint'(VAL_MAX)) r = VAL_MAX;
               else if (r < longint'(VAL_MIN)) r = VAL_MIN;
            end
            skdm_pkg::POLICY_AVG: r = (b >= a) ? a + (b - a) / n : a - (a - b) / n;
            skdm_pkg::POLICY_MAX: if (b > a) r = b;
            skdm_pkg::POLICY_MIN: if (b < a) r = b;
            skdm_pkg::POLICY_LAST: r = b;
            default: r = a;
         endcase
         return r[VW-1:0];
      endfunction

      function void note_entry(logic [IW-1:0] row, logic [IW-1:0] col,
                               logic signed [VW-1:0] value, logic last);
         if (held && row == held_row && col == held_col) begin
            if (held_count != '1) held_count++;
            held_value = fold(value);
         end else begin
            if (held) flush_held(1'b0);
            held = 1'b1;
            held_row = row;
            held_col = col;
            held_value = value;
            held_count = 1;
         end
         if (last) begin
            flush_held(1'b1);
            clear_held();
         end
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         faults++;
         $display("%0t: %s: got %h, wanted %h", $time, what, got, want);
      endtask

      task check_merged(merged_entry_type got);
         merged_entry_type want;
         if (awaited.size() == 0) begin
            report("merged word with none predicted, out_row", got.row, '0);
            return;
         end
         want = awaited.pop_front();
         if (got.row !== want.row) report("out_row", got.row, want.row);
         if (got.col !== want.col) report("out_col", got.col, want.col);
         if (got.value !== want.value) report("out_value", got.value, want.value);
         if (got.count !== want.count) report("merged_count", got.count, want.count);
         if (got.fin !== want.fin) report("final_result", got.fin, want.fin);
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   int                   send_idle_pct;
   int                   recv_idle_pct;
   int                   quiet_cycles = 0;
   merge_scoreboard_type ledger = new();

   skdm_req_if req_chan ();
   skdm_rsp_if rsp_chan ();
   skdm_csr_if csr_chan ();

   sorted_key_duplicate_merge_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      merged_entry_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.row = rsp_chan.out_row;
         got.col = rsp_chan.out_col;
         got.value = rsp_chan.out_value;
         got.count = rsp_chan.merged_count;
         got.fin = rsp_chan.final_result;
         ledger.check_merged(got);
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_entry(logic [IW-1:0] row, logic [IW-1:0] col,
                             logic signed [VW-1:0] value, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.row_index <= row;
      req_chan.col_index <= col;
      req_chan.entry_value <= value;
      req_chan.stream_end <= last;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      ledger.note_entry(row, col, value, last);
   endtask

   task automatic write_policy(logic [PW-1:0] p);
      csr_chan.valid <= 1'b1;
      csr_chan.merge_policy <= p;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      csr_chan.valid <= 1'b0;
      ledger.set_policy(p);
   endtask

   // A merge produces no word, so the divider may still be busy after the last word.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [VW-1:0] pick_value();
      logic signed [VW-1:0] v;
      case ($urandom_range(7))
         0: v = VAL_MAX;
         1: v = VAL_MIN;
         2: v = VAL_MAX - $urandom_range(65535);
         3: v = VAL_MIN + $urandom_range(65535);
         4: v = $urandom_range(131072) - 65536;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic run_stream(int entries);
      logic [IW-1:0] row;
      logic [IW-1:0] col;
      int            run_left;
      logic          last;
      row = $urandom;
      col = $urandom;
      run_left = 0;
      for (int i = 0; i < entries; i++) begin
         if (run_left == 0) begin
            case ($urandom_range(19))
               0, 1, 2: begin
                  row = $urandom;
                  col = $urandom;
               end
               3, 4, 5, 6: begin
                  row = row + $urandom_range(1, 8);
                  col = $urandom;
               end
               7: col = $urandom;
               default: col = col + $urandom_range(1, 16);
            endcase
            case ($urandom_range(19))
               0, 1, 2, 3, 4, 5, 6, 7: run_left = 1;
               16, 17, 18: run_left = $urandom_range(5, 10);
               19: run_left = $urandom_range(11, 40);
               default: run_left = $urandom_range(2, 4);
            endcase
         end
         if ($urandom_range(9) == 0) begin
            send_entry($urandom, $urandom, pick_value(), $urandom_range(7) == 0);
         end else begin
            last = (run_left == 1 && $urandom_range(4) == 0) || $urandom_range(39) == 0;
            send_entry(row, col, pick_value(), last);
            run_left--;
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.row_index <= '0;
      req_chan.col_index <= '0;
      req_chan.entry_value <= '0;
      req_chan.stream_end <= 1'b0;
      csr_chan.valid <= 1'b0;
      csr_chan.merge_policy <= '0;
      send_idle_pct = 24;
      recv_idle_pct = 50;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      drain();
      write_policy(skdm_pkg::POLICY_SUM);
      send_entry(1, 1, VAL_MAX, 1'b0);
      send_entry(1, 1, 1, 1'b0);
      send_entry(1, 1, VAL_MIN, 1'b0);
      send_entry(1, 1, VAL_MIN, 1'b0);
      send_entry(1, 2, 5, 1'b1);

      drain();
      write_policy(skdm_pkg::POLICY_AVG);
      send_entry(0, 0, VAL_MIN, 1'b0);
      send_entry(0, 0, VAL_MAX, 1'b0);
      send_entry(0, 0, -7, 1'b1);

      drain();
      write_policy(skdm_pkg::POLICY_MAX);
      send_entry('1, '1, -5, 1'b0);
      send_entry('1, '1, 3, 1'b0);
      send_entry('1, '1, 3, 1'b1);

      drain();
      write_policy(skdm_pkg::POLICY_MIN);
      send_entry(5, 0, 0, 1'b0);
      send_entry(5, 0, -1, 1'b0);
      send_entry(5, 0, VAL_MAX, 1'b0);
      send_entry(6, 0, 1, 1'b1);

      drain();
      write_policy(skdm_pkg::POLICY_LAST);
      send_entry(7, 7, 1, 1'b0);
      send_entry(7, 7, 2, 1'b1);

      drain();
      write_policy(POLICY_UNDEFINED);
      send_entry(8, 8, 9, 1'b0);
      send_entry(8, 8, 100, 1'b0);
      send_entry(9, 9, VAL_MIN, 1'b1);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 4) begin
            send_idle_pct = 50;
            recv_idle_pct = 24;
         end
         if (phase == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         drain();
         write_policy(PW'((phase * 3) % 8));
         run_stream(PHASE_ENTRIES);
      end

      drain();
      if (ledger.faults == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/skdm_pkg.sv
sv/skdm_ifs.sv
sv/skdm_div.sv
sv/skdm_datapath.sv
sv/skdm_ctrl.sv
sv/sorted_key_duplicate_merge_top.sv
tb/sv/testbench.sv
